// File: rtl/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg
// shared widths, codes and default sizes of the partition slice scheduler
// ----------------------------------------------------------------------------
package tpss_pkg;

  // default storage sizes
  localparam int MAX_CORES_DEF      = 4;
  localparam int MAX_SLICES_DEF     = 64;
  localparam int MAX_PARTITIONS_DEF = 32;

  // transaction field widths
  localparam int CORE_W  = 2;
  localparam int SLICE_W = 6;
  localparam int ENTRY_W = 6;
  localparam int PART_W  = 5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CORES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES     = 2'd2;

  // command opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // idle marker in the running partition registers
  localparam logic signed [ENTRY_W-1:0] PART_IDLE = -6'sd1;

endpackage

// File: rtl/tpss_cmd_if.sv
// ----------------------------------------------------------------------------
// tpss_cmd_if
// command channel: schedule table writes and slice ticks
// ----------------------------------------------------------------------------
interface tpss_cmd_if;
  import tpss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [SLICE_W-1:0]         slice_index;
  logic [CORE_W-1:0]          core_index;
  logic signed [ENTRY_W-1:0]  table_partition;

  modport source (output valid, op, slice_index, core_index, table_partition, input ready);
  modport sink   (input valid, op, slice_index, core_index, table_partition, output ready);
endinterface

// File: rtl/tpss_res_if.sv
// ----------------------------------------------------------------------------
// tpss_res_if
// result channel: one transaction per core walked on a tick
// ----------------------------------------------------------------------------
interface tpss_res_if;
  import tpss_pkg::*;

  logic               valid;
  logic               ready;
  logic [CORE_W-1:0]  core_out;
  logic               stop_valid;
  logic [PART_W-1:0]  stopped_partition;
  logic               resume_valid;
  logic [PART_W-1:0]  resumed_partition;
  logic               migrate;
  logic               release_valid;
  logic [PART_W-1:0]  release_partition;
  logic [SLICE_W-1:0] slice_out;
  logic               last;

  modport source (output valid, core_out, stop_valid, stopped_partition, resume_valid,
                  resumed_partition, migrate, release_valid, release_partition,
                  slice_out, last, input ready);
  modport sink   (input valid, core_out, stop_valid, stopped_partition, resume_valid,
                  resumed_partition, migrate, release_valid, release_partition,
                  slice_out, last, output ready);
endinterface

// File: rtl/tpss_ram.sv
// ----------------------------------------------------------------------------
// tpss_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tpss_ram #(
  parameter int  WIDTH = 6,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/time_partition_slice_scheduler.sv
// ----------------------------------------------------------------------------
// time_partition_slice_scheduler
// cyclic time-partition scheduler over a slice-by-core schedule table
// ----------------------------------------------------------------------------
// sequencing: a table write is taken in the idle state; a tick is accepted there and then
//   walks each core through table read, host-core read and evaluate, held by result stalls;
//   each result is loaded into the result register from the evaluate state
// throughput: one command at a time; a tick over zero cores only advances the frame
// reset: synchronous; slice counter to 0, every core idle, host cores read 0,
//   schedule table contents undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module time_partition_slice_scheduler #(
  parameter int MAX_CORES      = tpss_pkg::MAX_CORES_DEF,
  parameter int MAX_SLICES     = tpss_pkg::MAX_SLICES_DEF,
  parameter int MAX_PARTITIONS = tpss_pkg::MAX_PARTITIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpss_pkg::CFG_DATA_W-1:0]  cfg_data,
  tpss_cmd_if.sink                         cmd,
  tpss_res_if.source                       res
);
  import tpss_pkg::*;

  // derived widths
  localparam int CW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int SCW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int TD  = MAX_SLICES * MAX_CORES;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
  localparam int HAW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

  // one-hot walk sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,  // takes commands
    S_FETCH = 4'b0010,  // table read for the current core
    S_LOOK  = 4'b0100,  // table data back, host-core read
    S_EVAL  = 4'b1000   // decide and load the result register
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [2:0] cores_in_use;
  logic [5:0] partitions_in_use;
  logic [6:0] slices_in_use;

  // scheduler state
  logic [SCW-1:0]            slice_cnt;
  logic [CW-1:0]             core;
  logic signed [ENTRY_W-1:0] running [MAX_CORES];
  logic signed [ENTRY_W-1:0] want;
  logic [MAX_PARTITIONS-1:0] host_vld;
  logic                      host_seen;

  // memory ports
  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr;
  logic [TAW-1:0] tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic           host_we;
  logic [HAW-1:0] host_waddr;
  logic [HAW-1:0] host_raddr;
  logic [CW-1:0]  host_rdata;

  // result register
  logic               res_valid;
  logic [CORE_W-1:0]  r_core;
  logic               r_stop;
  logic [PART_W-1:0]  r_stop_p;
  logic               r_resume;
  logic [PART_W-1:0]  r_resume_p;
  logic               r_migrate;
  logic               r_release;
  logic [PART_W-1:0]  r_release_p;
  logic [SLICE_W-1:0] r_slice;
  logic               r_last;

  // decision logic
  logic signed [ENTRY_W-1:0] cur;
  logic [CW-1:0] host_val;
  logic chg, cur_ok, want_ok, stop_c, resume_c, migrate_c, release_c;
  logic [PART_W-1:0] release_p_c;
  logic cmd_acc, tick_acc, write_acc, out_free, load, last_core, no_cores;
  logic [SCW-1:0] slice_wrap;

  // partition number is valid: non-negative and below both limits
  function automatic logic part_ok(input logic signed [ENTRY_W-1:0] p,
                                   input logic [5:0] lim);
    return !p[ENTRY_W-1] && (32'(p[PART_W-1:0]) < 32'(lim))
           && (32'(p[PART_W-1:0]) < MAX_PARTITIONS);
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign tick_acc  = cmd_acc && (cmd.op == OP_TICK);
  assign write_acc = cmd_acc && (cmd.op == OP_WRITE);
  assign no_cores  = (cores_in_use == 3'd0);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cores_in_use      <= 3'd4;
      partitions_in_use <= 6'd0;
      slices_in_use     <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORES:      cores_in_use      <= cfg_data[2:0];
        REG_PARTITIONS: partitions_in_use <= cfg_data[5:0];
        REG_SLICES:     slices_in_use     <= cfg_data;
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ---------------- schedule table ----------------
  // out-of-range writes are dropped
  assign tbl_we = write_acc && (32'(cmd.slice_index) < MAX_SLICES)
                  && (32'(cmd.core_index) < MAX_CORES);
  assign tbl_waddr = TAW'(32'(cmd.slice_index) * MAX_CORES + 32'(cmd.core_index));
  assign tbl_raddr = TAW'(32'(slice_cnt) * MAX_CORES + 32'(core));

  tpss_ram #(.WIDTH(ENTRY_W), .DEPTH(TD)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (cmd.table_partition),
    .re    (state == S_FETCH),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // ---------------- host core memory ----------------
  // remembers the core each partition last ran on; entries never written read 0
  assign host_raddr = HAW'(tbl_rdata[PART_W-1:0]);
  assign host_waddr = HAW'(want[PART_W-1:0]);
  assign host_we    = load && resume_c;

  tpss_ram #(.WIDTH(CW), .DEPTH(MAX_PARTITIONS)) u_host (
    .clk   (clk),
    .we    (host_we),
    .waddr (host_waddr),
    .wdata (core),
    .re    (state == S_LOOK),
    .raddr (host_raddr),
    .rdata (host_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      host_vld <= '0;
    end else if (host_we) begin
      host_vld[host_waddr] <= 1'b1;
    end
  end

  // ---------------- per-core decision ----------------
  assign cur       = running[core];
  assign host_val  = host_seen ? host_rdata : '0;
  assign chg       = (want != cur);
  assign cur_ok    = part_ok(cur, partitions_in_use);
  assign want_ok   = part_ok(want, partitions_in_use);
  assign stop_c    = chg && cur_ok;
  assign resume_c  = chg && want_ok;
  assign migrate_c = resume_c && (host_val != core);
  // new partition gets a release; an unchanged valid one only at frame start
  assign release_c = resume_c || (!chg && (slice_cnt == '0) && cur_ok);
  assign release_p_c = resume_c ? want[PART_W-1:0] : cur[PART_W-1:0];

  assign out_free  = !res_valid || res.ready;
  assign load      = (state == S_EVAL) && out_free;
  assign last_core = (32'(core) + 1 >= 32'(cores_in_use)) || (32'(core) + 1 >= MAX_CORES);

  // next slice, wrapping at the frame end; a zero-length frame stays at 0
  always_comb begin
    slice_wrap = SCW'(32'(slice_cnt) + 1);
    if ((32'(slice_cnt) + 1 >= 32'(slices_in_use)) || (32'(slice_cnt) + 1 >= MAX_SLICES)) begin
      slice_wrap = '0;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (tick_acc && !no_cores) state_next = S_FETCH;
      S_FETCH: state_next = S_LOOK;
      S_LOOK:  state_next = S_EVAL;
      S_EVAL:  if (load) state_next = last_core ? S_IDLE : S_FETCH;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      core      <= '0;
      slice_cnt <= '0;
      host_seen <= 1'b0;
      for (int i = 0; i < MAX_CORES; i++) begin
        running[i] <= PART_IDLE;
      end
    end else begin
      state <= state_next;
      if (tick_acc) begin
        core <= '0;
        // a tick over no cores only advances the frame
        if (no_cores) begin
          slice_cnt <= slice_wrap;
        end
      end
      if (state == S_LOOK) begin
        host_seen <= host_vld[host_raddr];
      end
      if (load) begin
        if (chg) begin
          running[core] <= want_ok ? want : PART_IDLE;
        end
        if (last_core) begin
          slice_cnt <= slice_wrap;
        end else begin
          core <= core + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      want <= tbl_rdata;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // partition fields read zero whenever their flag is clear
  always_ff @(posedge clk) begin
    if (load) begin
      r_core      <= CORE_W'(core);
      r_stop      <= stop_c;
      r_stop_p    <= stop_c ? cur[PART_W-1:0] : '0;
      r_resume    <= resume_c;
      r_resume_p  <= resume_c ? want[PART_W-1:0] : '0;
      r_migrate   <= migrate_c;
      r_release   <= release_c;
      r_release_p <= release_c ? release_p_c : '0;
      r_slice     <= SLICE_W'(slice_cnt);
      r_last      <= last_core;
    end
  end

  assign res.valid             = res_valid;
  assign res.core_out          = r_core;
  assign res.stop_valid        = r_stop;
  assign res.stopped_partition = r_stop_p;
  assign res.resume_valid      = r_resume;
  assign res.resumed_partition = r_resume_p;
  assign res.migrate           = r_migrate;
  assign res.release_valid     = r_release;
  assign res.release_partition = r_release_p;
  assign res.slice_out         = r_slice;
  assign res.last              = r_last;

endmodule

// File: rtl/tpss_checker.sv
// ----------------------------------------------------------------------------
// tpss_checker
// port-level checks of the partition slice scheduler, bound to the top level
// ----------------------------------------------------------------------------
module tpss_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         cmd_op,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [tpss_pkg::CORE_W-1:0]  core_out,
  input logic                         stop_valid,
  input logic [tpss_pkg::PART_W-1:0]  stopped_partition,
  input logic                         resume_valid,
  input logic [tpss_pkg::PART_W-1:0]  resumed_partition,
  input logic                         migrate,
  input logic                         release_valid,
  input logic [tpss_pkg::PART_W-1:0]  release_partition,
  input logic [tpss_pkg::SLICE_W-1:0] slice_out,
  input logic                         last
);
  import tpss_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({core_out, stop_valid,
      stopped_partition, resume_valid, resumed_partition, migrate,
      release_valid, release_partition, slice_out, last}))
    else $error("result changed while stalled");

  // a table write never starts a result
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op == OP_WRITE) |=> !$rose(res_valid))
    else $error("result after a table write");

  // a new result only comes out of a core walk in progress
  a_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!cmd_ready))
    else $error("result raised while idle");

  // migration only with a resume, and flag-gated partition fields are zero
  a_migrate: assert property (@(posedge clk) disable iff (rst)
    res_valid && migrate |-> resume_valid)
    else $error("migrate without resume");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (stop_valid || stopped_partition == '0)
      && (resume_valid || resumed_partition == '0)
      && (release_valid || release_partition == '0))
    else $error("partition field set with its flag clear");

endmodule

bind time_partition_slice_scheduler tpss_checker u_tpss_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .cmd_op            (cmd.op),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .core_out          (res.core_out),
  .stop_valid        (res.stop_valid),
  .stopped_partition (res.stopped_partition),
  .resume_valid      (res.resume_valid),
  .resumed_partition (res.resumed_partition),
  .migrate           (res.migrate),
  .release_valid     (res.release_valid),
  .release_partition (res.release_partition),
  .slice_out         (res.slice_out),
  .last              (res.last)
);
